/* rtl/pbwf_pkg.sv */
package pbwf_pkg;

    // sizing of the length and offset counters
    localparam int LENGTH_BITS = 32;
    localparam int OFFSET_BITS = 32;

    localparam logic [28:0] MAX_FIELD_RESET = 29'h1fff_ffff;

    // result kinds
    localparam logic [2:0] KIND_SCALAR  = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_FIELD_ZERO     = 4'd1;
    localparam logic [3:0] ST_FIELD_TOO_BIG  = 4'd2;
    localparam logic [3:0] ST_GROUP          = 4'd3;
    localparam logic [3:0] ST_RESERVED_TYPE  = 4'd4;
    localparam logic [3:0] ST_VARINT_OVERFLOW = 4'd5;
    localparam logic [3:0] ST_VARINT_LONG    = 4'd6;
    localparam logic [3:0] ST_LENGTH_TOO_BIG = 4'd7;
    localparam logic [3:0] ST_TRUNCATED      = 4'd8;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_GSTART  = 3'd3;
    localparam logic [2:0] WT_GEND    = 3'd4;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [28:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        last;
        logic [3:0]  status;
        logic [31:0] offset;
    } result_t;

endpackage

/* rtl/protobuf_wire_field_parser_unit.sv */
// Path: a byte beat is registered at the input; its result (if any) is registered again for m_.
// Throughput: one input beat per cycle unless m_tready stalls the output; the parser update is
// combinational between the input register and the result register.
// Reset: synchronous active-low aresetn clears parser state, both register valids and
// sets max_field to its largest value; no clearing pass.
module protobuf_wire_field_parser_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [28:0]   cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] data_byte
    input  logic          s_tuser,   // [0] opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,   // [28:0] field_number, [31:29] wire_kind, [95:32] value,
                                     // [103:96] payload_byte, [107:104] status,
                                     // [139:108] offset, [143:140] zero
    output logic [2:0]    m_tuser,   // [2:0] kind
    output logic          m_tlast    // last
);
    import pbwf_pkg::*;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic [28:0] max_field_reg;
    logic        stage_free;
    logic        process;
    logic        res_valid;
    result_t     res;
    result_t     out_data;

    assign process  = in_valid_reg && stage_free;
    assign s_tready = !in_valid_reg || stage_free;

    // input register and config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            max_field_reg <= MAX_FIELD_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_wr_en) begin
                max_field_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    pbwf_parse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (process),
        .item_opcode (in_op_reg),
        .item_byte   (in_byte_reg),
        .max_field   (max_field_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    pbwf_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (process && res_valid),
        .load_data (res),
        .free      (stage_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    // beat packing
    assign m_tdata = {4'b0000, out_data.offset, out_data.status, out_data.payload_byte,
                      out_data.value, out_data.wire_kind, out_data.field_number};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

/* rtl/pbwf_parse_core.sv */
module pbwf_parse_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  logic              item_opcode,
    input  logic [7:0]        item_byte,
    input  logic [28:0]       max_field,
    output logic              res_valid,
    output pbwf_pkg::result_t res
);
    import pbwf_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG, PH_VALUE, PH_LEN, PH_FIXED, PH_PAYLOAD, PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {VI_MORE, VI_DONE, VI_OVF, VI_LONG} vi_code_t;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  idx;
        vi_code_t    code;
    } vi_res_t;

    // mask of the bits a length may use
    localparam logic [63:0] LEN_MASK =
        (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

    phase_t                   phase_reg, phase_next;
    logic [63:0]              acc_reg, acc_next;
    logic [3:0]               idx_reg, idx_next;
    logic [28:0]              field_reg, field_next;
    logic [2:0]               type_reg, type_next;
    logic [LENGTH_BITS-1:0]   remain_reg, remain_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [3:0]               err_reg, err_next;

    logic [OFFSET_BITS-1:0]   tag_start;
    logic [63:0]              tag_acc;
    vi_res_t                  vi_tag, vi_val;
    logic [60:0]              tag_fn;
    logic [2:0]               tag_wt;
    logic [63:0]              fixed_acc;
    logic [3:0]               fixed_idx;
    logic [3:0]               fixed_width;
    logic [LENGTH_BITS-1:0]   remain_dec;
    logic [3:0]               end_status;

    // one byte of a base-128 varint
    function automatic vi_res_t varint_take(input logic [63:0] acc, input logic [3:0] idx,
                                            input logic [7:0] b);
        vi_res_t r;
        logic [5:0] sh;
        r.acc  = acc;
        r.idx  = idx;
        r.code = VI_MORE;
        sh     = 6'(7 * idx);
        if (idx == 4'd9 && b[6:0] > 7'h01) begin
            r.code = VI_OVF;
        end else begin
            r.acc = acc | (64'(b[6:0]) << sh);
            if (!b[7]) begin
                r.code = VI_DONE;
            end else begin
                r.idx = idx + 4'd1;
                if (r.idx >= 4'd10) begin
                    r.code = VI_LONG;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] vi_status(input vi_code_t c);
        return (c == VI_OVF) ? ST_VARINT_OVERFLOW : ST_VARINT_LONG;
    endfunction

    // shared decode terms
    assign tag_start   = (idx_reg == 4'd0) ? pos_reg : start_reg;
    assign tag_acc     = (idx_reg == 4'd0) ? 64'd0 : acc_reg;
    assign vi_tag      = varint_take(tag_acc, idx_reg, item_byte);
    assign vi_val      = varint_take(acc_reg, idx_reg, item_byte);
    assign tag_fn      = vi_tag.acc[63:3];
    assign tag_wt      = vi_tag.acc[2:0];
    assign fixed_acc   = acc_reg | (64'(item_byte) << {idx_reg[2:0], 3'b000});
    assign fixed_idx   = idx_reg + 4'd1;
    assign fixed_width = (type_reg == WT_FIXED64) ? 4'd8 : 4'd4;
    assign remain_dec  = remain_reg - LENGTH_BITS'(1);
    assign end_status  = (err_reg != ST_OK) ? err_reg :
                         ((phase_reg != PH_TAG || idx_reg != 4'd0) ? ST_TRUNCATED : ST_OK);

    // next state and result for the beat in hand
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        field_next  = field_reg;
        type_next   = type_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        err_next    = err_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (item_opcode == OP_END) begin
            res_valid    = 1'b1;
            res.kind     = KIND_END;
            res.status   = end_status;
            res.offset   = 32'(pos_reg);
            phase_next   = PH_TAG;
            acc_next     = '0;
            idx_next     = '0;
            field_next   = '0;
            type_next    = '0;
            remain_next  = '0;
            pos_next     = '0;
            start_next   = '0;
            err_next     = ST_OK;
        end else begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            case (phase_reg)
                PH_TAG: begin
                    start_next = tag_start;
                    if (vi_tag.code == VI_MORE) begin
                        acc_next = vi_tag.acc;
                        idx_next = vi_tag.idx;
                    end else if (vi_tag.code != VI_DONE) begin
                        // tag varint broken: field and type still those of before
                        acc_next         = vi_tag.acc;
                        idx_next         = vi_tag.idx;
                        phase_next       = PH_ERROR;
                        err_next         = vi_status(vi_tag.code);
                        res_valid        = 1'b1;
                        res.kind         = KIND_ERROR;
                        res.field_number = field_reg;
                        res.wire_kind    = type_reg;
                        res.status       = vi_status(vi_tag.code);
                        res.offset       = 32'(tag_start);
                    end else begin
                        field_next = tag_fn[28:0];
                        type_next  = tag_wt;
                        acc_next   = '0;
                        idx_next   = '0;
                        res.field_number = tag_fn[28:0];
                        res.wire_kind    = tag_wt;
                        res.kind         = KIND_ERROR;
                        res.offset       = 32'(tag_start);
                        if (tag_fn == 61'd0) begin
                            res.status = ST_FIELD_ZERO;
                        end else if (tag_fn > 61'(max_field)) begin
                            res.status = ST_FIELD_TOO_BIG;
                        end else if (tag_wt == WT_GSTART || tag_wt == WT_GEND) begin
                            res.status = ST_GROUP;
                        end else if (tag_wt > WT_FIXED32) begin
                            res.status = ST_RESERVED_TYPE;
                        end
                        if (res.status != ST_OK) begin
                            res_valid  = 1'b1;
                            phase_next = PH_ERROR;
                            err_next   = res.status;
                        end else if (tag_wt == WT_VARINT) begin
                            phase_next = PH_VALUE;
                        end else if (tag_wt == WT_LENGTH) begin
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = PH_FIXED;
                        end
                    end
                end
                PH_VALUE, PH_LEN: begin
                    res.field_number = field_reg;
                    res.wire_kind    = type_reg;
                    if (vi_val.code == VI_MORE) begin
                        acc_next = vi_val.acc;
                        idx_next = vi_val.idx;
                    end else if (vi_val.code != VI_DONE) begin
                        // offset points back by the count of bytes taken
                        acc_next   = vi_val.acc;
                        idx_next   = vi_val.idx;
                        phase_next = PH_ERROR;
                        err_next   = vi_status(vi_val.code);
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.status = vi_status(vi_val.code);
                        res.offset = 32'(pos_reg - OFFSET_BITS'(vi_val.idx));
                    end else begin
                        acc_next  = '0;
                        idx_next  = '0;
                        res_valid = 1'b1;
                        if (phase_reg == PH_VALUE) begin
                            res.kind   = KIND_SCALAR;
                            res.value  = vi_val.acc;
                            res.offset = 32'(start_reg);
                            phase_next = PH_TAG;
                        end else if ((vi_val.acc & ~LEN_MASK) != 64'd0) begin
                            res.kind   = KIND_ERROR;
                            res.status = ST_LENGTH_TOO_BIG;
                            res.offset = 32'(pos_next);
                            phase_next = PH_ERROR;
                            err_next   = ST_LENGTH_TOO_BIG;
                        end else begin
                            res.kind    = KIND_HEADER;
                            res.value   = vi_val.acc;
                            res.last    = (vi_val.acc == 64'd0);
                            res.offset  = 32'(start_reg);
                            remain_next = LENGTH_BITS'(vi_val.acc);
                            phase_next  = (vi_val.acc == 64'd0) ? PH_TAG : PH_PAYLOAD;
                        end
                    end
                end
                PH_FIXED: begin
                    // little-endian assembly, one byte per beat
                    acc_next = fixed_acc;
                    idx_next = fixed_idx;
                    if (fixed_idx >= fixed_width) begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_SCALAR;
                        res.field_number = field_reg;
                        res.wire_kind    = type_reg;
                        res.value        = fixed_acc;
                        res.offset       = 32'(start_reg);
                        acc_next         = '0;
                        idx_next         = '0;
                        phase_next       = PH_TAG;
                    end
                end
                PH_PAYLOAD: begin
                    remain_next      = remain_dec;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.field_number = field_reg;
                    res.wire_kind    = type_reg;
                    res.payload_byte = item_byte;
                    res.last         = (remain_dec == '0);
                    res.offset       = 32'(start_reg);
                    if (remain_dec == '0) begin
                        phase_next = PH_TAG;
                    end
                end
                default: begin
                    // sticky error: bytes only move the position on
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TAG;
            acc_reg    <= '0;
            idx_reg    <= '0;
            field_reg  <= '0;
            type_reg   <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            err_reg    <= ST_OK;
        end else if (item_valid) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            field_reg  <= field_next;
            type_reg   <= type_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            err_reg    <= err_next;
        end
    end

endmodule

/* rtl/pbwf_out_stage.sv */
module pbwf_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  pbwf_pkg::result_t load_data,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output pbwf_pkg::result_t m_data
);
    import pbwf_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // room when empty or when the held beat leaves this cycle
    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule
